>>> sv/vrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the voxel ray traversal block.
// No dependencies; used by all modules but vrt_div.
package vrt_pkg;

    localparam int GRID_BITS_DEF = 5;
    localparam int FRAC_BITS_DEF = 16;

    localparam int DIR_W      = 16;
    localparam int LEN2_W     = 32;
    localparam int L8_W       = 24;
    localparam int CELL_W     = 11;
    localparam int OUT_CELL_W = 5;
    localparam int FACE_W     = 3;
    localparam int TYPE_W     = 8;
    localparam int REACH_W    = 16;
    localparam int REACH_FRAC = 8;

    localparam logic [REACH_W-1:0] REACH_RESET = 16'd1280;
    localparam logic [LEN2_W-1:0]  LEN2_MIN    = 32'd11;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_T,
        OP_TZERO,
        OP_TDEL,
        OP_MUL_STEP,
        OP_TMAX,
        OP_RD,
        OP_ADV,
        OP_FY_MUL,
        OP_FY_DIV,
        OP_OUT_HIT,
        OP_OUT_MISS
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic       short_len;
        logic       sqrt_last;
        logic       mul_last;
        logic       div_done;
        logic [2:0] axis_en;
        logic       walk_go;
        logic       solid;
    } status_t;

endpackage

>>> sv/vrt_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by the datapath.
// No package dependencies.
module vrt_div #(
    parameter int NW = 47,
    parameter int DW = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CNT_W = $clog2(NW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    assign trial = {rem_reg, n_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            n_next   = {n_reg[NW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = n_reg;

endmodule

>>> sv/vrt_datapath.sv
`timescale 1ns / 1ps
// Datapath: voxel memory, ray setup arithmetic, DDA walk registers, result.
// Depends on vrt_pkg and vrt_div; driven by vrt_ctrl commands.
module vrt_datapath #(
    parameter int GRID_BITS = vrt_pkg::GRID_BITS_DEF,
    parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  vrt_pkg::cmd_t                        cmd,
    output vrt_pkg::status_t                     status,
    input  logic                                 cfg_write_en,
    input  logic [vrt_pkg::REACH_W-1:0]          cfg_write_data,
    input  logic                                 action,
    input  logic [GRID_BITS-1:0]                 cell_x,
    input  logic [GRID_BITS-1:0]                 cell_y,
    input  logic [GRID_BITS-1:0]                 cell_z,
    input  logic [vrt_pkg::TYPE_W-1:0]           cell_value,
    input  logic signed [FRAC_BITS+5:0]          origin_x,
    input  logic signed [FRAC_BITS+5:0]          origin_y,
    input  logic signed [FRAC_BITS+5:0]          origin_z,
    input  logic signed [vrt_pkg::DIR_W-1:0]     dir_x,
    input  logic signed [vrt_pkg::DIR_W-1:0]     dir_y,
    input  logic signed [vrt_pkg::DIR_W-1:0]     dir_z,
    output logic                                 hit,
    output logic [vrt_pkg::OUT_CELL_W-1:0]       hit_x,
    output logic [vrt_pkg::OUT_CELL_W-1:0]       hit_y_cell,
    output logic [vrt_pkg::OUT_CELL_W-1:0]       hit_z,
    output logic [vrt_pkg::FACE_W-1:0]           entry_face,
    output logic [FRAC_BITS+7:0]                 hit_distance,
    output logic [vrt_pkg::TYPE_W-1:0]           hit_type,
    output logic [FRAC_BITS:0]                   hit_fraction_y
);

    localparam int ORG_W   = FRAC_BITS + 6;
    localparam int DIST_W  = FRAC_BITS + 8;
    localparam int TD_W    = FRAC_BITS + 16;
    localparam int TM_W    = FRAC_BITS + 17;
    localparam int G_W     = FRAC_BITS + 1;
    localparam int ACC_W   = G_W + TD_W;
    localparam int DIV_NW  = FRAC_BITS + 31;
    localparam int DIV_DW  = vrt_pkg::L8_W;
    localparam int AW      = 3 * GRID_BITS;
    localparam int DEPTH   = 1 << AW;
    localparam int SQ_W    = vrt_pkg::LEN2_W + 16;
    localparam int REM_W   = vrt_pkg::L8_W + 2;
    localparam int PROD_W  = vrt_pkg::DIR_W + DIST_W;
    localparam int FY_W    = FRAC_BITS + vrt_pkg::CELL_W + 2;
    localparam int IT_MAX  = (vrt_pkg::L8_W > G_W) ? vrt_pkg::L8_W : G_W;
    localparam int IT_W    = $clog2(IT_MAX);
    localparam int CW      = vrt_pkg::CELL_W;
    localparam int DW      = vrt_pkg::DIR_W;

    localparam logic signed [FY_W-1:0] ONE_FY = FY_W'(1) <<< FRAC_BITS;
    localparam logic [G_W-1:0]         ONE_G  = G_W'(1) << FRAC_BITS;

    logic [vrt_pkg::TYPE_W-1:0] mem [DEPTH];

    logic signed [ORG_W-1:0] org_reg  [3];
    logic signed [DW-1:0]    d_reg    [3];
    logic signed [CW-1:0]    cell_reg [3];
    logic [TD_W-1:0]         tdel_reg [3];
    logic [TM_W-1:0]         tmax_reg [3];
    logic [TM_W-1:0]         dist_reg;
    logic [vrt_pkg::FACE_W-1:0] face_reg;
    logic [vrt_pkg::LEN2_W-1:0] len2_reg;
    logic [SQ_W-1:0]         sq_src_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [vrt_pkg::L8_W-1:0] l8_reg;
    logic [TD_W-1:0]         md_reg;
    logic [G_W-1:0]          g_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [IT_W-1:0]         cnt_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [vrt_pkg::TYPE_W-1:0] rd_data_reg;
    logic                    in_grid_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic [vrt_pkg::REACH_W-1:0] max_reach_reg;

    logic                    hit_reg;
    logic [vrt_pkg::OUT_CELL_W-1:0] hx_reg, hy_reg, hz_reg;
    logic [vrt_pkg::FACE_W-1:0] face_out_reg;
    logic [DIST_W-1:0]       dist_out_reg;
    logic [vrt_pkg::TYPE_W-1:0] type_reg;
    logic [FRAC_BITS:0]      fy_reg;

    logic [DW-1:0]           mag [3];
    logic [G_W-1:0]          gval [3];
    logic [2:0]              en;
    logic [1:0]              sel;
    logic signed [2*DW-1:0]  sq;
    logic [REM_W-1:0]        sq_trial, sq_t;
    logic [DIST_W-1:0]       reach;
    logic                    div_start, div_done;
    logic [DIV_NW-1:0]       div_num, div_quo;
    logic [DIV_DW-1:0]       div_den;
    logic                    mem_we;
    logic [AW-1:0]           mem_wa, rd_addr;
    logic [vrt_pkg::TYPE_W-1:0] mem_wd;
    logic [DIST_W-1:0]       term;
    logic signed [FY_W-1:0]  fy_org, fy_term, fy_cell, fy_raw;
    logic [FRAC_BITS:0]      fy_clamp;

    function automatic logic earlier(input logic ae, input logic [TM_W-1:0] a,
                                     input logic be, input logic [TM_W-1:0] b);
        return ae && (!be || (a < b));
    endfunction

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mag[a]  = d_reg[a][DW-1] ? DW'(~d_reg[a] + 1'b1) : DW'(d_reg[a]);
            gval[a] = d_reg[a][DW-1] ? {1'b0, org_reg[a][FRAC_BITS-1:0]}
                                     : ONE_G - {1'b0, org_reg[a][FRAC_BITS-1:0]};
            en[a]   = d_reg[a] != '0;
        end
        if (earlier(en[0], tmax_reg[0], en[1], tmax_reg[1]) &&
            earlier(en[0], tmax_reg[0], en[2], tmax_reg[2]))
            sel = 2'd0;
        else if (earlier(en[1], tmax_reg[1], en[2], tmax_reg[2]))
            sel = 2'd1;
        else
            sel = 2'd2;
    end

    assign sq       = d_reg[cmd.axis] * d_reg[cmd.axis];
    assign sq_t     = {rem_reg[REM_W-3:0], sq_src_reg[SQ_W-1 -: 2]};
    assign sq_trial = {l8_reg, 2'b01};
    assign reach    = {max_reach_reg, {(FRAC_BITS - vrt_pkg::REACH_FRAC){1'b0}}};

    assign div_start = (cmd.op == vrt_pkg::OP_DIV_T) || (cmd.op == vrt_pkg::OP_FY_DIV);
    assign div_num   = (cmd.op == vrt_pkg::OP_DIV_T)
                     ? DIV_NW'({l8_reg, {FRAC_BITS{1'b0}}})
                     : {prod_reg[PROD_W-2:0], 8'b0};
    assign div_den   = (cmd.op == vrt_pkg::OP_DIV_T) ? {mag[cmd.axis], 8'b0} : l8_reg;

    vrt_div #(
        .NW(DIV_NW),
        .DW(DIV_DW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (div_quo)
    );

    assign mem_we  = (cmd.op == vrt_pkg::OP_CLEAR) || ((cmd.op == vrt_pkg::OP_LOAD) && !action);
    assign mem_wa  = (cmd.op == vrt_pkg::OP_CLEAR) ? clr_addr_reg : {cell_z, cell_y, cell_x};
    assign mem_wd  = (cmd.op == vrt_pkg::OP_CLEAR) ? '0 : cell_value;
    assign rd_addr = {cell_reg[2][GRID_BITS-1:0], cell_reg[1][GRID_BITS-1:0],
                      cell_reg[0][GRID_BITS-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (cmd.op == vrt_pkg::OP_RD)
            rd_data_reg <= mem[rd_addr];
    end

    // hit point y relative to the hit cell
    always_comb
    begin
        term    = div_quo[DIST_W-1:0];
        fy_org  = FY_W'(org_reg[1]);
        fy_term = $signed({{(FY_W - DIST_W){1'b0}}, term});
        if (d_reg[1][DW-1])
            fy_term = -fy_term;
        fy_cell = FY_W'(cell_reg[1]) <<< FRAC_BITS;
        fy_raw  = fy_org + fy_term - fy_cell;
        if (fy_raw < 0)
            fy_clamp = '0;
        else if (fy_raw > ONE_FY)
            fy_clamp = ONE_FY[FRAC_BITS:0];
        else
            fy_clamp = fy_raw[FRAC_BITS:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            clr_addr_reg  <= '0;
            max_reach_reg <= vrt_pkg::REACH_RESET;
        end
        else
        begin
            if (cfg_write_en)
                max_reach_reg <= cfg_write_data;
            if (cmd.op == vrt_pkg::OP_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if ((cmd.op == vrt_pkg::OP_SQRT_INIT) || (cmd.op == vrt_pkg::OP_TDEL))
                cnt_reg <= '0;
            else if ((cmd.op == vrt_pkg::OP_SQRT_STEP) || (cmd.op == vrt_pkg::OP_MUL_STEP))
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            vrt_pkg::OP_LOAD:
            begin
                org_reg[0] <= origin_x;
                org_reg[1] <= origin_y;
                org_reg[2] <= origin_z;
                d_reg[0]   <= dir_x;
                d_reg[1]   <= dir_y;
                d_reg[2]   <= dir_z;
                cell_reg[0] <= CW'(origin_x >>> FRAC_BITS);
                cell_reg[1] <= CW'(origin_y >>> FRAC_BITS);
                cell_reg[2] <= CW'(origin_z >>> FRAC_BITS);
                dist_reg   <= '0;
                face_reg   <= '0;
                len2_reg   <= '0;
            end
            vrt_pkg::OP_SQ:
                len2_reg <= len2_reg + vrt_pkg::LEN2_W'($unsigned(sq));
            vrt_pkg::OP_SQRT_INIT:
            begin
                sq_src_reg <= {len2_reg, 16'b0};
                rem_reg    <= '0;
                l8_reg     <= '0;
            end
            vrt_pkg::OP_SQRT_STEP:
            begin
                sq_src_reg <= {sq_src_reg[SQ_W-3:0], 2'b00};
                if (sq_t >= sq_trial)
                begin
                    rem_reg <= sq_t - sq_trial;
                    l8_reg  <= {l8_reg[vrt_pkg::L8_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= sq_t;
                    l8_reg  <= {l8_reg[vrt_pkg::L8_W-2:0], 1'b0};
                end
            end
            vrt_pkg::OP_TZERO:
            begin
                tdel_reg[cmd.axis] <= '0;
                tmax_reg[cmd.axis] <= '0;
            end
            vrt_pkg::OP_TDEL:
            begin
                tdel_reg[cmd.axis] <= div_quo[TD_W-1:0];
                md_reg  <= div_quo[TD_W-1:0];
                g_reg   <= gval[cmd.axis];
                acc_reg <= '0;
            end
            vrt_pkg::OP_MUL_STEP:
            begin
                acc_reg <= {acc_reg[ACC_W-2:0], 1'b0} +
                           (g_reg[G_W-1] ? ACC_W'(md_reg) : ACC_W'(0));
                g_reg   <= {g_reg[G_W-2:0], 1'b0};
            end
            vrt_pkg::OP_TMAX:
                tmax_reg[cmd.axis] <= acc_reg[FRAC_BITS +: TM_W];
            vrt_pkg::OP_RD:
                in_grid_reg <= (cell_reg[0][CW-1:GRID_BITS] == '0) &&
                               (cell_reg[1][CW-1:GRID_BITS] == '0) &&
                               (cell_reg[2][CW-1:GRID_BITS] == '0);
            vrt_pkg::OP_ADV:
            begin
                dist_reg      <= tmax_reg[sel];
                tmax_reg[sel] <= tmax_reg[sel] + TM_W'(tdel_reg[sel]);
                cell_reg[sel] <= d_reg[sel][DW-1] ? cell_reg[sel] - 1'b1
                                                  : cell_reg[sel] + 1'b1;
                face_reg      <= {sel, ~d_reg[sel][DW-1]};
            end
            vrt_pkg::OP_FY_MUL:
                prod_reg <= mag[1] * dist_reg[DIST_W-1:0];
            vrt_pkg::OP_OUT_HIT:
            begin
                hit_reg      <= 1'b1;
                hx_reg       <= cell_reg[0][vrt_pkg::OUT_CELL_W-1:0];
                hy_reg       <= cell_reg[1][vrt_pkg::OUT_CELL_W-1:0];
                hz_reg       <= cell_reg[2][vrt_pkg::OUT_CELL_W-1:0];
                face_out_reg <= face_reg;
                dist_out_reg <= dist_reg[DIST_W-1:0];
                type_reg     <= rd_data_reg;
                fy_reg       <= fy_clamp;
            end
            vrt_pkg::OP_OUT_MISS:
            begin
                hit_reg      <= 1'b0;
                hx_reg       <= '0;
                hy_reg       <= '0;
                hz_reg       <= '0;
                face_out_reg <= '0;
                dist_out_reg <= '0;
                type_reg     <= '0;
                fy_reg       <= '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        status.clear_last = clr_addr_reg == {AW{1'b1}};
        status.short_len  = len2_reg < vrt_pkg::LEN2_MIN;
        status.sqrt_last  = cnt_reg == IT_W'(vrt_pkg::L8_W - 1);
        status.mul_last   = cnt_reg == IT_W'(FRAC_BITS);
        status.div_done   = div_done;
        status.axis_en    = en;
        status.walk_go    = dist_reg < TM_W'(reach);
        status.solid      = in_grid_reg && (rd_data_reg != '0);
    end

    assign hit            = hit_reg;
    assign hit_x          = hx_reg;
    assign hit_y_cell     = hy_reg;
    assign hit_z          = hz_reg;
    assign entry_face     = face_out_reg;
    assign hit_distance   = dist_out_reg;
    assign hit_type       = type_reg;
    assign hit_fraction_y = fy_reg;

endmodule

>>> sv/vrt_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences memory clear, ray setup and DDA walk.
// Depends on vrt_pkg; commands vrt_datapath.
module vrt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_action,
    input  logic             out_stall,
    input  vrt_pkg::status_t status,
    output vrt_pkg::cmd_t    cmd,
    output logic             in_stall,
    output logic             out_valid
);

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_SQ    = 15'b000000000000100,
        S_LCHK  = 15'b000000000001000,
        S_SQRT  = 15'b000000000010000,
        S_AXIS  = 15'b000000000100000,
        S_DIV   = 15'b000000001000000,
        S_MUL   = 15'b000000010000000,
        S_MEND  = 15'b000000100000000,
        S_CHK   = 15'b000001000000000,
        S_EV    = 15'b000010000000000,
        S_FYD   = 15'b000100000000000,
        S_FYW   = 15'b001000000000000,
        S_HIT   = 15'b010000000000000,
        S_MISS  = 15'b100000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = vrt_pkg::OP_NONE;
        cmd.axis       = axis_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = vrt_pkg::OP_CLEAR;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = vrt_pkg::OP_LOAD;
                    if (in_action)
                    begin
                        state_next = S_SQ;
                        axis_next  = 2'd0;
                    end
                end
            end
            S_SQ:
            begin
                cmd.op = vrt_pkg::OP_SQ;
                if (axis_reg == 2'd2)
                begin
                    state_next = S_LCHK;
                    axis_next  = 2'd0;
                end
                else
                    axis_next = axis_reg + 1'b1;
            end
            S_LCHK:
            begin
                if (status.short_len)
                    state_next = S_MISS;
                else
                begin
                    cmd.op     = vrt_pkg::OP_SQRT_INIT;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op = vrt_pkg::OP_SQRT_STEP;
                if (status.sqrt_last)
                begin
                    state_next = S_AXIS;
                    axis_next  = 2'd0;
                end
            end
            S_AXIS:
            begin
                if (status.axis_en[axis_reg])
                begin
                    cmd.op     = vrt_pkg::OP_DIV_T;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.op = vrt_pkg::OP_TZERO;
                    if (axis_reg == 2'd2)
                        state_next = S_CHK;
                    else
                        axis_next = axis_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.op     = vrt_pkg::OP_TDEL;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.op = vrt_pkg::OP_MUL_STEP;
                if (status.mul_last)
                    state_next = S_MEND;
            end
            S_MEND:
            begin
                cmd.op = vrt_pkg::OP_TMAX;
                if (axis_reg == 2'd2)
                    state_next = S_CHK;
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_AXIS;
                end
            end
            S_CHK:
            begin
                if (status.walk_go)
                begin
                    cmd.op     = vrt_pkg::OP_RD;
                    state_next = S_EV;
                end
                else
                    state_next = S_MISS;
            end
            S_EV:
            begin
                if (status.solid)
                begin
                    cmd.op     = vrt_pkg::OP_FY_MUL;
                    state_next = S_FYD;
                end
                else
                begin
                    cmd.op     = vrt_pkg::OP_ADV;
                    state_next = S_CHK;
                end
            end
            S_FYD:
            begin
                cmd.op     = vrt_pkg::OP_FY_DIV;
                state_next = S_FYW;
            end
            S_FYW:
            begin
                if (status.div_done)
                    state_next = S_HIT;
            end
            S_HIT:
            begin
                if (out_free)
                begin
                    cmd.op         = vrt_pkg::OP_OUT_HIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (out_free)
                begin
                    cmd.op         = vrt_pkg::OP_OUT_MISS;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            axis_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == vrt_pkg::OP_OUT_HIT || cmd.op == vrt_pkg::OP_OUT_MISS)
        |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending transaction");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_DIV || state_reg == S_FYW))
        else $error("divider finished outside a wait state");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_HIT || state_reg == S_MISS))
        else $error("result raised without a finished ray");

endmodule

>>> sv/voxel_ray_traversal.sv
`timescale 1ns / 1ps
// Voxel ray traversal: voxel grid store plus 3D DDA ray walker.
// Uses vrt_pkg, vrt_ctrl, vrt_datapath (which holds vrt_div).
//
// Input channel (in_valid/in_stall): a transaction with action 0 writes
// cell_value into the grid as it is accepted; action 1 casts a ray. Output
// channel (out_valid/out_stall): one result transaction per ray, none per
// write. max_reach is written through cfg_write_en/cfg_write_data.
// A ray sums the squared direction over the three axes, checks the length
// (a too short direction ends as a miss) and takes the square root; then
// per axis with a nonzero direction the divider gives tDelta and a serial
// multiply the first boundary crossing, while a zero axis is zeroed. The
// walk then reads the voxel memory once per visited cell. A hit computes
// the hit fraction before the result load; a miss loads the result
// directly. One ray is in flight at a time.
// After reset the grid is cleared at one entry a cycle, all 2^(3*GRID_BITS)
// entries (32768 at the default), with in_stall high; configuration writes
// are taken meanwhile. A finished result waits in the output register while
// out_stall is high, and the next item is accepted in the meantime.
module voxel_ray_traversal #(
    parameter int GRID_BITS = vrt_pkg::GRID_BITS_DEF,
    parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [vrt_pkg::REACH_W-1:0]       cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [GRID_BITS-1:0]              cell_x,
    input  logic [GRID_BITS-1:0]              cell_y,
    input  logic [GRID_BITS-1:0]              cell_z,
    input  logic [vrt_pkg::TYPE_W-1:0]        cell_value,
    input  logic signed [FRAC_BITS+5:0]       origin_x,
    input  logic signed [FRAC_BITS+5:0]       origin_y,
    input  logic signed [FRAC_BITS+5:0]       origin_z,
    input  logic signed [vrt_pkg::DIR_W-1:0]  dir_x,
    input  logic signed [vrt_pkg::DIR_W-1:0]  dir_y,
    input  logic signed [vrt_pkg::DIR_W-1:0]  dir_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic [vrt_pkg::OUT_CELL_W-1:0]    hit_x,
    output logic [vrt_pkg::OUT_CELL_W-1:0]    hit_y_cell,
    output logic [vrt_pkg::OUT_CELL_W-1:0]    hit_z,
    output logic [vrt_pkg::FACE_W-1:0]        entry_face,
    output logic [FRAC_BITS+7:0]              hit_distance,
    output logic [vrt_pkg::TYPE_W-1:0]        hit_type,
    output logic [FRAC_BITS:0]                hit_fraction_y
);

    vrt_pkg::cmd_t    cmd;
    vrt_pkg::status_t status;

    vrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_action(action),
        .out_stall(out_stall),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall),
        .out_valid(out_valid)
    );

    vrt_datapath #(
        .GRID_BITS(GRID_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .action        (action),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .cell_z        (cell_z),
        .cell_value    (cell_value),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .origin_z      (origin_z),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .hit           (hit),
        .hit_x         (hit_x),
        .hit_y_cell    (hit_y_cell),
        .hit_z         (hit_z),
        .entry_face    (entry_face),
        .hit_distance  (hit_distance),
        .hit_type      (hit_type),
        .hit_fraction_y(hit_fraction_y)
    );

endmodule
